@@ rtl/qrs_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// qrs_pkg
// Types and constants shared by the quadratic root solver cells and top level.
// ============================================================================
package qrs_pkg;

   // Coefficient and result widths.
   localparam int COEF_W = 16;
   localparam int OUT_W  = 32;

   // Square root: radicand is |d| shifted up by 16, one root bit per cell.
   localparam int MAG_W  = 34;
   localparam int RAD_W  = 50;
   localparam int ROOT_W = 25;
   localparam int REM_W  = 28;

   // Division: numerator magnitude, divisor magnitude, one quotient bit per cell.
   localparam int NUM_W  = 34;
   localparam int DEN_W  = 16;
   localparam int DREM_W = 16;
   localparam int LANES  = 3;

   // Values carried alongside the square root.
   typedef struct packed {
      logic signed [COEF_W-1:0] coef_a;
      logic signed [COEF_W-1:0] coef_b;
      logic                     d_neg;
      logic                     a_zero;
   } sqrt_side_type;

   typedef struct packed {
      logic [RAD_W-1:0]  rad;
      logic [REM_W-1:0]  rem;
      logic [ROOT_W-1:0] root;
      sqrt_side_type     side;
   } sqrt_cell_type;

   // One divider lane: numerator shifts out, quotient shifts in at the bottom.
   typedef struct packed {
      logic [NUM_W-1:0]  num;
      logic [DREM_W-1:0] rem;
      logic              neg;
   } div_lane_type;

   typedef struct packed {
      logic is_complex;
      logic no_quadratic;
   } div_side_type;

   typedef struct packed {
      div_lane_type [LANES-1:0] lane;
      logic [DEN_W-1:0]         den;
      div_side_type             side;
   } div_cell_type;

   // One result transaction.
   typedef struct packed {
      logic signed [OUT_W-1:0] root_minus;
      logic signed [OUT_W-1:0] root_plus;
      logic signed [OUT_W-1:0] imag_part;
      logic                    is_complex;
      logic                    no_quadratic;
      logic                    saturated;
   } rsp_data_type;

endpackage
`default_nettype wire

@@ rtl/qrs_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// qrs_req_if
// Coefficient channel: valid, ready and one set of Q8.8 coefficients.
// ============================================================================
interface qrs_req_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] coef_a;
   logic signed [15:0] coef_b;
   logic signed [15:0] coef_c;

   modport source (output valid, output coef_a, output coef_b, output coef_c, input ready);
   modport sink   (input valid, input coef_a, input coef_b, input coef_c, output ready);
endinterface
`default_nettype wire

@@ rtl/qrs_rsp_if.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// qrs_rsp_if
// Result channel: valid, ready and the roots with their flags.
// ============================================================================
interface qrs_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] root_minus;
   logic signed [31:0] root_plus;
   logic signed [31:0] imag_part;
   logic               is_complex;
   logic               no_quadratic;
   logic               saturated;

   modport source (output valid, output root_minus, output root_plus, output imag_part,
                   output is_complex, output no_quadratic, output saturated, input ready);
   modport sink   (input valid, input root_minus, input root_plus, input imag_part,
                   input is_complex, input no_quadratic, input saturated, output ready);
endinterface
`default_nettype wire

@@ rtl/qrs_sqrt_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// qrs_sqrt_cell
// One restoring square root step: brings down two radicand bits, yields one
// root bit.
// ============================================================================
module qrs_sqrt_cell (
   input  wire logic                   clock,
   input  wire logic                   en,
   input  wire qrs_pkg::sqrt_cell_type cell_in,
   output qrs_pkg::sqrt_cell_type      cell_out
);
   import qrs_pkg::*;

   sqrt_cell_type     out_ff;
   sqrt_cell_type     out_in;
   logic [REM_W-1:0]  rem2;
   logic [REM_W-1:0]  trial;

   // Trial subtraction of (root * 4 + 1) from the shifted remainder.
   always_comb begin
      rem2   = {cell_in.rem[REM_W-3:0], cell_in.rad[RAD_W-1 -: 2]};
      trial  = {1'b0, cell_in.root, 2'b01};
      out_in = cell_in;
      out_in.rad = {cell_in.rad[RAD_W-3:0], 2'b00};
      if (rem2 >= trial) begin
         out_in.rem  = rem2 - trial;
         out_in.root = {cell_in.root[ROOT_W-2:0], 1'b1};
      end else begin
         out_in.rem  = rem2;
         out_in.root = {cell_in.root[ROOT_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign cell_out = out_ff;
endmodule
`default_nettype wire

@@ rtl/qrs_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// qrs_div_cell
// One restoring division step for each of three lanes sharing one divisor.
// ============================================================================
module qrs_div_cell (
   input  wire logic                  clock,
   input  wire logic                  en,
   input  wire qrs_pkg::div_cell_type cell_in,
   output qrs_pkg::div_cell_type      cell_out
);
   import qrs_pkg::*;

   div_cell_type      out_ff;
   div_cell_type      out_in;
   logic [DREM_W:0]   rem2 [LANES];

   // Shift in the next numerator bit and subtract the divisor where it fits.
   always_comb begin
      out_in = cell_in;
      for (int i = 0; i < LANES; i++) begin
         rem2[i] = {cell_in.lane[i].rem, cell_in.lane[i].num[NUM_W-1]};
         if (rem2[i] >= {1'b0, cell_in.den}) begin
            out_in.lane[i].rem = DREM_W'(rem2[i] - {1'b0, cell_in.den});
            out_in.lane[i].num = {cell_in.lane[i].num[NUM_W-2:0], 1'b1};
         end else begin
            out_in.lane[i].rem = rem2[i][DREM_W-1:0];
            out_in.lane[i].num = {cell_in.lane[i].num[NUM_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         out_ff <= out_in;
      end
   end

   assign cell_out = out_ff;
endmodule
`default_nettype wire

@@ rtl/quadratic_root_solver_unit.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Throughput: one transaction per cycle while the spare output entry is empty,
// set by a pipeline of 25 square root cells and 34 divider cells, one bit each,
// behind a product stage and a discriminant stage.
// A two-entry output buffer keeps the pipeline moving while a result waits.
// Reset (synchronous, active high) clears all valid bits; data is not reset.
// ============================================================================
// quadratic_root_solver_unit
// Pipelined quadratic solver: discriminant, bit-serial square root chain and
// divider chain, then sign, saturation and flags.
// ============================================================================
module quadratic_root_solver_unit (
   input  wire logic clock,
   input  wire logic reset,
   qrs_req_if.sink   req_bus,
   qrs_rsp_if.source rsp_bus
);
   import qrs_pkg::*;

   localparam int STAGES = 2 + ROOT_W + 1 + NUM_W;

   logic                  en;
   logic [STAGES-1:0]     v_ff;
   logic signed [31:0]    bb_ff, ac_ff;
   logic signed [15:0]    a0_ff, b0_ff;
   sqrt_cell_type         sq [ROOT_W+1];
   div_cell_type          dv [NUM_W+1];
   sqrt_cell_type         p1_in;
   sqrt_cell_type         sq0_ff;
   div_cell_type          num_in;
   div_cell_type          num_ff;
   logic signed [34:0]    d_w;
   rsp_data_type          res_w;
   rsp_data_type          out_ff, sp_ff;
   logic                  out_v_ff, sp_v_ff;

   assign en = !sp_v_ff;
   assign req_bus.ready = en;

   // Valid bits shift with the pipeline.
   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= {v_ff[STAGES-2:0], req_bus.valid};
      end
   end

   // Stage one: products.
   always_ff @(posedge clock) begin
      if (en) begin
         bb_ff <= req_bus.coef_b * req_bus.coef_b;
         ac_ff <= req_bus.coef_a * req_bus.coef_c;
         a0_ff <= req_bus.coef_a;
         b0_ff <= req_bus.coef_b;
      end
   end

   // Stage two: discriminant and its magnitude as the radicand.
   always_comb begin
      d_w = 35'(bb_ff) - {ac_ff[31], ac_ff, 2'b00};
      p1_in.rad = {(d_w[34] ? MAG_W'(-d_w) : MAG_W'(d_w)), 16'b0};
      p1_in.rem = '0;
      p1_in.root = '0;
      p1_in.side.coef_a = a0_ff;
      p1_in.side.coef_b = b0_ff;
      p1_in.side.d_neg  = d_w[34];
      p1_in.side.a_zero = (a0_ff == '0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         sq0_ff <= p1_in;
      end
   end

   assign sq[0] = sq0_ff;

   // Square root chain.
   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      qrs_sqrt_cell u_cell (.clock(clock), .en(en), .cell_in(sq[k]), .cell_out(sq[k+1]));
   end

   // Numerators, quotient signs and divisor.
   always_comb begin
      logic signed [16:0] nb;
      logic signed [26:0] nb256, s27, nm, np;
      logic [15:0]        absb;
      logic               a_neg;
      nb    = -{sq[ROOT_W].side.coef_b[15], sq[ROOT_W].side.coef_b};
      nb256 = {{2{nb[16]}}, nb, 8'b0};
      s27   = {2'b00, sq[ROOT_W].root};
      nm    = nb256 - s27;
      np    = nb256 + s27;
      absb  = sq[ROOT_W].side.coef_b[15] ? 16'(-sq[ROOT_W].side.coef_b)
                                         : 16'(sq[ROOT_W].side.coef_b);
      a_neg = sq[ROOT_W].side.coef_a[15];
      num_in = '0;
      num_in.den = a_neg ? 16'(-sq[ROOT_W].side.coef_a) : 16'(sq[ROOT_W].side.coef_a);
      num_in.side.is_complex   = sq[ROOT_W].side.d_neg;
      num_in.side.no_quadratic = sq[ROOT_W].side.a_zero;
      num_in.lane[2].num = {2'b00, sq[ROOT_W].root, 7'b0};
      num_in.lane[2].neg = a_neg;
      if (sq[ROOT_W].side.d_neg) begin
         num_in.lane[0].num = {3'b000, absb, 15'b0};
         num_in.lane[0].neg = nb[16] ^ a_neg;
         num_in.lane[1] = num_in.lane[0];
      end else begin
         num_in.lane[0].num = {(nm[26] ? 27'(-nm) : 27'(nm)), 7'b0};
         num_in.lane[0].neg = nm[26] ^ a_neg;
         num_in.lane[1].num = {(np[26] ? 27'(-np) : 27'(np)), 7'b0};
         num_in.lane[1].neg = np[26] ^ a_neg;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         num_ff <= num_in;
      end
   end

   assign dv[0] = num_ff;

   // Divider chain.
   for (genvar k = 0; k < NUM_W; k++) begin : g_div
      qrs_div_cell u_cell (.clock(clock), .en(en), .cell_in(dv[k]), .cell_out(dv[k+1]));
   end

   // Apply sign and clip a quotient magnitude to the Q16.16 range.
   function automatic logic [OUT_W:0] clip_q(input logic [NUM_W-1:0] mag, input logic neg);
      logic [OUT_W-1:0] v;
      logic             sat;
      sat = 1'b0;
      if (!neg && mag > NUM_W'(32'h7FFF_FFFF)) begin
         v   = 32'h7FFF_FFFF;
         sat = 1'b1;
      end else if (neg && mag > NUM_W'(33'h1_0000_0000 >> 1)) begin
         v   = 32'h8000_0000;
         sat = 1'b1;
      end else begin
         v = neg ? -mag[OUT_W-1:0] : mag[OUT_W-1:0];
      end
      return {sat, v};
   endfunction

   always_comb begin
      logic [OUT_W:0] q0, q1, q2;
      q0 = clip_q(dv[NUM_W].lane[0].num, dv[NUM_W].lane[0].neg);
      q1 = clip_q(dv[NUM_W].lane[1].num, dv[NUM_W].lane[1].neg);
      q2 = clip_q(dv[NUM_W].lane[2].num, dv[NUM_W].lane[2].neg);
      res_w = '0;
      if (dv[NUM_W].side.no_quadratic) begin
         res_w.no_quadratic = 1'b1;
      end else if (dv[NUM_W].side.is_complex) begin
         res_w.root_minus = q0[OUT_W-1:0];
         res_w.root_plus  = q0[OUT_W-1:0];
         res_w.imag_part  = q2[OUT_W-1:0];
         res_w.is_complex = 1'b1;
         res_w.saturated  = q0[OUT_W] | q2[OUT_W];
      end else begin
         res_w.root_minus = q0[OUT_W-1:0];
         res_w.root_plus  = q1[OUT_W-1:0];
         res_w.saturated  = q0[OUT_W] | q1[OUT_W];
      end
   end

   // Output register with a spare entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
         sp_v_ff  <= 1'b0;
      end else if (!out_v_ff || rsp_bus.ready) begin
         if (sp_v_ff) begin
            out_ff   <= sp_ff;
            out_v_ff <= 1'b1;
            sp_v_ff  <= 1'b0;
         end else begin
            out_ff   <= res_w;
            out_v_ff <= v_ff[STAGES-1];
         end
      end else if (en && v_ff[STAGES-1]) begin
         sp_ff   <= res_w;
         sp_v_ff <= 1'b1;
      end
   end

   assign rsp_bus.valid        = out_v_ff;
   assign rsp_bus.root_minus   = out_ff.root_minus;
   assign rsp_bus.root_plus    = out_ff.root_plus;
   assign rsp_bus.imag_part    = out_ff.imag_part;
   assign rsp_bus.is_complex   = out_ff.is_complex;
   assign rsp_bus.no_quadratic = out_ff.no_quadratic;
   assign rsp_bus.saturated    = out_ff.saturated;

   // The spare entry is only ever filled behind a held output.
   a_spare: assert property (@(posedge clock) disable iff (reset) sp_v_ff |-> out_v_ff)
      else $error("spare entry valid without output valid");

   // A degenerate equation carries no roots and no other flags.
   a_noquad: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.no_quadratic) |->
      (!rsp_bus.is_complex && !rsp_bus.saturated && rsp_bus.root_minus == 0))
      else $error("no_quadratic result with nonzero fields");

   // Real roots have no imaginary part.
   a_real: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.is_complex) |-> (rsp_bus.imag_part == 0))
      else $error("real result with nonzero imaginary part");

   // Complex roots share one real part.
   a_cplx: assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && rsp_bus.is_complex) |-> (rsp_bus.root_minus == rsp_bus.root_plus))
      else $error("complex result with differing real parts");
endmodule
`default_nettype wire
